// ===== rtl/core/bit_set_membership_engine_defines.svh =====
// Assertion macros for the membership bitmap engine.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BIT_SET_MEMBERSHIP_ENGINE_DEFINES_SVH
`define BIT_SET_MEMBERSHIP_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define BSME_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bsme assertion failed");
`define BSME_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bsme assertion failed");
`else
`define BSME_ASSERT(lbl, clk, rstn, prop)
`define BSME_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/bsme_pkg.sv =====
// Shared constants, opcodes and controller/datapath interface types for the
// membership bitmap engine. No dependencies.
package bsme_pkg;

  localparam int CAPACITY = 4096;
  localparam int WORD_W   = 32;
  localparam int ROWS     = CAPACITY / WORD_W;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int IDX_W    = 12;
  localparam int SIZE_W   = 13;
  localparam int OP_W     = 3;

  localparam logic [SIZE_W-1:0] CAP_SIZE   = SIZE_W'(CAPACITY);
  localparam logic [SIZE_W-1:0] RESET_SIZE = (4096 > CAPACITY) ? SIZE_W'(CAPACITY)
                                                               : SIZE_W'(4096);

  typedef enum logic [OP_W-1:0] {
    OP_TEST       = 3'd0,
    OP_ADD        = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_FILL       = 3'd4,
    OP_COMPLEMENT = 3'd5,
    OP_COUNT      = 3'd6
  } op_e;

  typedef struct packed {
    logic capture;
    logic rd_sweep;
    logic modify;
    logic sweep_clr;
    logic sweep_wr;
    logic clear_all;
    logic count_fill;
    logic count_compl;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_err;
    logic            last_row;
  } status_t;

endpackage

// ===== rtl/core/bsme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bsme_dp.sv =====
// Datapath: bitmap word RAM, row valid bits, member count, size and result
// registers. Depends on bsme_pkg and bsme_ram.
module bsme_dp
  import bsme_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OP_W-1:0]   in_opcode_i,
  input  logic [IDX_W-1:0]  in_member_index_i,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output logic              out_is_member_o,
  output logic [SIZE_W-1:0] out_member_count_o,
  output logic              out_index_error_o
);

  localparam int FULL_W = SIZE_W - BIT_W;

  function automatic logic [WORD_W-1:0] row_mask(logic [ROW_W-1:0] row,
                                                 logic [SIZE_W-1:0] size);
    logic [FULL_W-1:0] full;
    logic [FULL_W-1:0] r;
    logic [WORD_W-1:0] m;
    full = size[SIZE_W-1:BIT_W];
    r    = FULL_W'(row);
    if (r < full) begin
      m = '1;
    end else if (r == full) begin
      m = (WORD_W'(1) << size[BIT_W-1:0]) - WORD_W'(1);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [SIZE_W-1:0] count_q, count_d;
  logic              hit_q, hit_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROWS-1:0]   valid_q, valid_d;
  logic              res_hit_q;
  logic [SIZE_W-1:0] res_count_q;
  logic              res_err_q;

  logic [ROW_W-1:0]  idx_row;
  logic [BIT_W-1:0]  idx_bit;
  logic [WORD_W-1:0] onehot;
  logic              idx_err;
  logic [ROW_W-1:0]  raddr;
  logic [ROW_W-1:0]  cur_row;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] cur;
  logic              cur_bit;
  logic [WORD_W-1:0] mask;
  logic              we;
  logic [ROW_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;

  assign idx_row = idx_q[IDX_W-1:BIT_W];
  assign idx_bit = idx_q[BIT_W-1:0];
  assign onehot  = WORD_W'(1) << idx_bit;
  assign idx_err = ((op_q == OP_TEST) || (op_q == OP_ADD) || (op_q == OP_REMOVE))
                   && ({1'b0, idx_q} >= size_q);
  assign raddr   = cmd_i.rd_sweep ? row_q : idx_row;
  assign cur_row = cmd_i.sweep_wr ? row_q : idx_row;
  assign cur     = valid_q[cur_row] ? rdata : '0;
  assign cur_bit = cur[idx_bit];
  assign mask    = row_mask(row_q, size_q);

  always_comb begin
    we    = 1'b0;
    waddr = idx_row;
    wdata = cur;
    if (cmd_i.modify && (op_q == OP_ADD)) begin
      we    = 1'b1;
      wdata = cur | onehot;
    end else if (cmd_i.modify && (op_q == OP_REMOVE)) begin
      we    = 1'b1;
      wdata = cur & ~onehot;
    end else if (cmd_i.sweep_wr) begin
      we    = 1'b1;
      waddr = row_q;
      wdata = (op_q == OP_FILL) ? mask : (~cur & mask);
    end
  end

  bsme_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ROWS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    size_d  = size_q;
    count_d = count_q;
    hit_d   = hit_q;
    row_d   = row_q;
    valid_d = valid_q;
    if (cfg_we_i) begin
      size_d = (cfg_wdata_i > CAP_SIZE) ? CAP_SIZE : cfg_wdata_i;
    end
    if (we) begin
      valid_d[waddr] = 1'b1;
    end
    if (cfg_we_i || cmd_i.clear_all) begin
      valid_d = '0;
      count_d = '0;
    end else if (cmd_i.count_fill) begin
      count_d = size_q;
    end else if (cmd_i.count_compl) begin
      count_d = size_q - count_q;
    end else if (cmd_i.modify && (op_q == OP_ADD) && !cur_bit) begin
      count_d = count_q + SIZE_W'(1);
    end else if (cmd_i.modify && (op_q == OP_REMOVE) && cur_bit) begin
      count_d = count_q - SIZE_W'(1);
    end
    if (cmd_i.capture) begin
      hit_d = 1'b0;
    end else if (cmd_i.modify && (op_q == OP_TEST)) begin
      hit_d = cur_bit;
    end
    if (cmd_i.sweep_clr) begin
      row_d = '0;
    end else if (cmd_i.sweep_wr) begin
      row_d = row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= RESET_SIZE;
      count_q <= '0;
      valid_q <= '0;
      hit_q   <= 1'b0;
      row_q   <= '0;
    end else begin
      size_q  <= size_d;
      count_q <= count_d;
      valid_q <= valid_d;
      hit_q   <= hit_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_opcode_i;
      idx_q <= in_member_index_i;
    end
    if (cmd_i.load_result) begin
      res_hit_q   <= hit_q;
      res_count_q <= count_q;
      res_err_q   <= idx_err;
    end
  end

  assign status_o.op       = op_q;
  assign status_o.idx_err  = idx_err;
  assign status_o.last_row = (row_q == ROW_W'(ROWS - 1));

  assign out_is_member_o    = res_hit_q;
  assign out_member_count_o = res_count_q;
  assign out_index_error_o  = res_err_q;

endmodule

// ===== rtl/core/bsme_ctrl.sv =====
// Controller state machine: sequences single-member updates and word sweeps,
// and owns the output valid. Depends on bsme_pkg and the assertion macros.
`include "bit_set_membership_engine_defines.svh"

module bsme_ctrl
  import bsme_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_MODIFY,
    S_SWEEP_RD,
    S_SWEEP_WR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_ISSUE;
        end
      end
      S_ISSUE: begin
        unique case (status_i.op) inside
          OP_TEST, OP_ADD, OP_REMOVE: begin
            state_d = status_i.idx_err ? S_DONE : S_MODIFY;
          end
          OP_CLEAR: begin
            cmd_o.clear_all = 1'b1;
            state_d         = S_DONE;
          end
          OP_FILL: begin
            cmd_o.sweep_clr  = 1'b1;
            cmd_o.count_fill = 1'b1;
            state_d          = S_SWEEP_WR;
          end
          OP_COMPLEMENT: begin
            cmd_o.sweep_clr   = 1'b1;
            cmd_o.count_compl = 1'b1;
            state_d           = S_SWEEP_RD;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_MODIFY: begin
        cmd_o.modify = 1'b1;
        state_d      = S_DONE;
      end
      S_SWEEP_RD: begin
        cmd_o.rd_sweep = 1'b1;
        state_d        = S_SWEEP_WR;
      end
      S_SWEEP_WR: begin
        cmd_o.sweep_wr = 1'b1;
        if (status_i.last_row) begin
          state_d = S_DONE;
        end else if (status_i.op == OP_FILL) begin
          state_d = S_SWEEP_WR;
        end else begin
          state_d = S_SWEEP_RD;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.load_result ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BSME_ASSERT(a_load_free, clk_i, rst_ni, cmd_o.load_result |-> slot_free)
  `BSME_ASSERT(a_modify_after_issue, clk_i, rst_ni, (state_q == S_MODIFY) |-> ($past(state_q) == S_ISSUE))
  `BSME_ASSERT(a_sweep_end, clk_i, rst_ni, (cmd_o.sweep_wr && status_i.last_row) |=> (state_q == S_DONE))
  `BSME_ASSERT(a_accept_issue, clk_i, rst_ni, cmd_o.capture |=> (state_q == S_ISSUE))

endmodule

// ===== rtl/core/bit_set_membership_engine.sv =====
// Membership bitmap engine with population count, 4096 members.
// Input channel: in_valid_i / in_stall_o with opcode and member index; output
// channel: out_valid_o / out_stall_i with is_member, member_count and
// index_error. A beat moves at an edge with valid high and stall low.
// One result beat follows every input beat, in order.
// Steps per item (controller sequencing the 32-bit word RAM):
//   test, add, remove: issue, modify, done;
//   clear, count, out-of-range index: issue, done;
//   fill: issue, one word written per cycle over 128 words, done;
//   complement: issue, read then write of each of 128 words, done.
// The result is registered and shows in the cycle after the done step loads it.
// The next input beat is taken while a result waits; the controller holds
// in its final step while the output is stalled and full.
// Reset: empty set, count zero, set_size 4096; no clearing pass, row valid
// bits empty the store at once. cfg_we_i writes set_size and empties the
// set; write it only while idle.
// Depends on bsme_pkg, bsme_ctrl, bsme_dp, bsme_ram.
module bit_set_membership_engine
  import bsme_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   in_opcode_i,
  input  logic [IDX_W-1:0]  in_member_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              out_is_member_o,
  output logic [SIZE_W-1:0] out_member_count_o,
  output logic              out_index_error_o,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  bsme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsme_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_opcode_i       (in_opcode_i),
    .in_member_index_i (in_member_index_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_is_member_o   (out_is_member_o),
    .out_member_count_o(out_member_count_o),
    .out_index_error_o (out_index_error_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bit_set_membership_engine: directed and random beats
// checked against an in-bench bitmap predictor. Depends on bsme_pkg and the RTL only.
module tb_top;
  import bsme_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_SLACK    = 6;
  localparam int MAX_REPORTS    = 60;

  typedef struct packed {
    logic              is_member;
    logic [SIZE_W-1:0] member_count;
    logic              index_error;
  } result_t;

  typedef enum {STALL_NONE, STALL_SPOTTY, STALL_LONG} stall_pattern_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   in_opcode_i;
  logic [IDX_W-1:0]  in_member_index_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              out_is_member_o;
  logic [SIZE_W-1:0] out_member_count_o;
  logic              out_index_error_o;
  logic              cfg_we_i;
  logic [SIZE_W-1:0] cfg_wdata_i;

  bit                present_bits [CAPACITY];
  int unsigned       present_total;
  logic [SIZE_W-1:0] size_reg;
  result_t           expected_results [$];

  int unsigned error_count;
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned sizes_written;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit          gaps_on;

  bit_set_membership_engine dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_opcode_i        (in_opcode_i),
    .in_member_index_i  (in_member_index_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_is_member_o    (out_is_member_o),
    .out_member_count_o (out_member_count_o),
    .out_index_error_o  (out_index_error_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned span_in_use();
    return (size_reg > CAPACITY) ? CAPACITY : int'(size_reg);
  endfunction

  function automatic void clear_bitmap();
    foreach (present_bits[i]) present_bits[i] = 1'b0;
    present_total = 0;
  endfunction

  function automatic result_t apply_member_op(input logic [OP_W-1:0] op,
                                              input logic [IDX_W-1:0] idx);
    int unsigned span;
    result_t     res;
    span = span_in_use();
    res  = '0;
    case (op) inside
      OP_TEST, OP_ADD, OP_REMOVE: begin
        if (idx >= span) begin
          res.index_error = 1'b1;
        end else if (op == OP_TEST) begin
          res.is_member = present_bits[idx];
        end else if (op == OP_ADD && !present_bits[idx]) begin
          present_bits[idx] = 1'b1;
          present_total++;
        end else if (op == OP_REMOVE && present_bits[idx]) begin
          present_bits[idx] = 1'b0;
          present_total--;
        end
      end
      OP_CLEAR: clear_bitmap();
      OP_FILL: begin
        for (int i = 0; i < span; i++) present_bits[i] = 1'b1;
        present_total = span;
      end
      OP_COMPLEMENT: begin
        for (int i = 0; i < span; i++) present_bits[i] = ~present_bits[i];
        present_total = span - present_total;
      end
      default: ;
    endcase
    res.member_count = SIZE_W'(present_total);
    return res;
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 30) return OP_TEST;
    if (roll < 55) return OP_ADD;
    if (roll < 74) return OP_REMOVE;
    if (roll < 80) return OP_COUNT;
    if (roll < 84) return OP_CLEAR;
    if (roll < 89) return OP_FILL;
    if (roll < 95) return OP_COMPLEMENT;
    return OP_UNUSED;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned span;
    int unsigned roll;
    span = span_in_use();
    roll = $urandom_range(99, 0);
    if (span == 0 || roll < 10) return IDX_W'($urandom);
    if (roll < 20) return IDX_W'((span < CAPACITY && roll < 15) ? span : span - 1);
    return IDX_W'($urandom_range(span - 1, 0));
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        pause_sender($urandom_range(8, 1));
      end
      burst_left--;
    end
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    in_opcode_i       <= op;
    in_member_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(apply_member_op(op, idx));
    beats_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic write_set_size(input logic [SIZE_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    size_reg = value;
    clear_bitmap();
    sizes_written++;
  endtask

  task automatic test_reset_state();
    gaps_on = 1'b0;
    send_beat(OP_COUNT, '0);
    send_beat(OP_TEST, '0);
    send_beat(OP_ADD, '0);
    send_beat(OP_ADD, '0);
    send_beat(OP_ADD, '1);
    send_beat(OP_TEST, '1);
    send_beat(OP_REMOVE, IDX_W'(1));
    send_beat(OP_REMOVE, '1);
    send_beat(OP_UNUSED, '1);
  endtask

  task automatic test_size_extremes();
    gaps_on = 1'b0;
    write_set_size('0);
    send_beat(OP_TEST, '0);
    send_beat(OP_FILL, '0);
    send_beat(OP_COMPLEMENT, '0);
    write_set_size('1);
    send_beat(OP_FILL, '0);
    send_beat(OP_REMOVE, '1);
    send_beat(OP_COMPLEMENT, '0);
    send_beat(OP_TEST, '1);
    write_set_size(SIZE_W'(8));
    send_beat(OP_FILL, '0);
    send_beat(OP_ADD, IDX_W'(8));
    send_beat(OP_COMPLEMENT, '0);
    send_beat(OP_ADD, IDX_W'(7));
    send_beat(OP_COUNT, '0);
    write_set_size(SIZE_W'(1));
    send_beat(OP_ADD, '0);
    send_beat(OP_CLEAR, '0);
    send_beat(OP_TEST, IDX_W'(1));
  endtask

  task automatic test_drain_pause();
    gaps_on = 1'b1;
    write_set_size(CAP_SIZE);
    repeat (60) send_beat(pick_op(), pick_index());
    // hold until every result is back, then resume
    drain_results();
    repeat (60) send_beat(pick_op(), pick_index());
  endtask

  task automatic test_random_phases();
    logic [SIZE_W-1:0] sizes [10];
    sizes = '{CAP_SIZE, '1, SIZE_W'(1), '0, SIZE_W'(8), SIZE_W'(100),
              SIZE_W'(4095), SIZE_W'(4097), SIZE_W'(2048), SIZE_W'($urandom)};
    foreach (sizes[p]) begin
      write_set_size(sizes[p]);
      gaps_on    = ($urandom_range(3, 0) != 0);
      burst_left = 0;
      repeat (165) send_beat(pick_op(), pick_index());
    end
  endtask

  // receiver: switch among free-running, spotty and long-stall stretches
  initial begin
    stall_pattern_e pattern_mode;
    int unsigned    pattern_left;
    int unsigned    hold_left;
    bit             stall_level;
    out_stall_i  = 1'b0;
    pattern_mode = STALL_NONE;
    pattern_left = 0;
    hold_left    = 0;
    stall_level  = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (pattern_left == 0) begin
        pattern_mode = stall_pattern_e'($urandom_range(2, 0));
        pattern_left = $urandom_range(300, 30);
        hold_left    = 0;
      end
      pattern_left--;
      if (hold_left == 0) begin
        case (pattern_mode)
          STALL_NONE: begin
            stall_level = 1'b0;
            hold_left   = 1;
          end
          STALL_SPOTTY: begin
            stall_level = ($urandom_range(2, 0) == 0);
            hold_left   = 1;
          end
          default: begin
            stall_level = ~stall_level;
            hold_left   = $urandom_range(stall_level ? 25 : 10, 1);
          end
        endcase
      end
      hold_left--;
      out_stall_i <= stall_level;
    end
  end

  always @(posedge clk_i) begin : check_beat
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.is_member    = out_is_member_o;
      got.member_count = out_member_count_o;
      got.index_error  = out_index_error_o;
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (got.is_member !== want.is_member)
          report_mismatch($sformatf("beat %0d is_member got %b want %b",
                                    beats_checked, got.is_member, want.is_member));
        if (got.member_count !== want.member_count)
          report_mismatch($sformatf("beat %0d member_count got %0d want %0d",
                                    beats_checked, got.member_count, want.member_count));
        if (got.index_error !== want.index_error)
          report_mismatch($sformatf("beat %0d index_error got %b want %b",
                                    beats_checked, got.index_error, want.index_error));
      end
      beats_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_results.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    in_opcode_i       = '0;
    in_member_index_i = '0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    beats_sent        = 0;
    sizes_written     = 0;
    burst_left        = 0;
    gaps_on           = 1'b0;
    size_reg          = RESET_SIZE;
    clear_bitmap();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_size_extremes();
    test_drain_pause();
    test_random_phases();

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d beats (%0d checked) over %0d set_size writes,", beats_sent,
             beats_checked, sizes_written);
    $display("including empty, single, full and above-capacity sets; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
